// ===== src/bqd_pkg.sv =====
// ----------------------------------------------------------------------------
// bqd_pkg: shared constants and types for the biquad low-pass unit
// Coefficient register map, reset values, default sizes and the control
// bundle that drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bqd_pkg;

	localparam int COEF_WIDTH          = 20;
	localparam int NUM_REGS            = 5;
	localparam int REG_IDX_BITS        = 3;

	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int COEF_FRAC_BITS_DEF  = 16;
	localparam int DELAY_BITS_DEF      = 32;

	// coefficient register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_B0 = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_B1 = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_B2 = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_A1 = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_A2 = 3'd4;

	// b0 resets to unity gain in Q3.16
	localparam logic signed [COEF_WIDTH-1:0] COEF_B0_RESET = 20'sh10000;

	typedef struct packed {
		logic issue;  // start a multiply this cycle
		logic hi;     // operand limb: upper half, weighted by the low limb width
		logic clear;  // load the accumulator with the rounding constant
	} bqd_mac_ctl_t;

endpackage

`default_nettype wire

// ===== src/bqd_in_if.sv =====
// ----------------------------------------------------------------------------
// bqd_in_if: input sample channel
// Valid/ready channel carrying one raw signed sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqd_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== src/bqd_out_if.sv =====
// ----------------------------------------------------------------------------
// bqd_out_if: filtered sample channel
// Valid/ready channel carrying one filtered sample and the guard flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqd_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          guard_hit;

	modport source (output valid, output sample_out, output guard_hit, input ready);
	modport sink   (input valid, input sample_out, input guard_hit, output ready);
endinterface

`default_nettype wire

// ===== src/biquad_lowpass_df2_unit.sv =====
// Samples are filtered one at a time; ten limb products share one multiplier.
// The result sits in an output register, so a new sample is taken while it waits.
// Reset: asynchronous, active low; clears delays, sequencer and output valid,
// and loads the coefficients with b0 = 1.0 and all others zero.
// ----------------------------------------------------------------------------
// biquad_lowpass_df2_unit: second-order IIR biquad, direct form II
// Feedback sum, overflow guard, feedforward sum and output saturation run
// under a small sequencer around the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_lowpass_df2_unit #(
	parameter int SAMPLE_BITS    = bqd_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF,
	parameter int DELAY_BITS     = bqd_pkg::DELAY_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [bqd_pkg::REG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [bqd_pkg::COEF_WIDTH-1:0]    cfg_data,
	bqd_in_if.sink                                 in_ch,
	bqd_out_if.source                              out_ch
);
	import bqd_pkg::*;

	localparam int ACC_W = COEF_WIDTH + DELAY_BITS + 3;
	localparam int WW    = ACC_W + 1;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_FB       = 3'd1;
	localparam logic [2:0] ST_FB_DRAIN = 3'd2;
	localparam logic [2:0] ST_W0       = 3'd3;
	localparam logic [2:0] ST_FF       = 3'd4;
	localparam logic [2:0] ST_FF_DRAIN = 3'd5;
	localparam logic [2:0] ST_OUT      = 3'd6;

	localparam logic [2:0] FB_LAST = 3'd3;
	localparam logic [2:0] FF_LAST = 3'd5;

	logic [2:0] state_q;
	logic [2:0] cnt_q;

	logic signed [COEF_WIDTH-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [DELAY_BITS-1:0]  d1_q, d2_q, w0_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          guard_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          out_guard_q;

	bqd_mac_ctl_t                  mac_ctl;
	logic signed [COEF_WIDTH-1:0]  mac_coef;
	logic signed [DELAY_BITS-1:0]  mac_opnd;
	logic signed [ACC_W-1:0]       acc;

	logic signed [ACC_W-1:0]       scaled;
	logic signed [WW-1:0]          w0_wide;
	logic                          w0_fits;
	logic                          y_fits;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	logic in_beat;
	logic out_free;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_beat     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= COEF_B0_RESET;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_B0:  b0_q <= signed'(cfg_data);
				REG_B1:  b1_q <= signed'(cfg_data);
				REG_B2:  b2_q <= signed'(cfg_data);
				REG_A1:  a1_q <= signed'(cfg_data);
				REG_A2:  a2_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// operand select and control for the shared unit
	always_comb begin
		mac_ctl.issue = 1'b0;
		mac_ctl.hi    = cnt_q[0];
		mac_ctl.clear = in_beat || (state_q == ST_W0);
		mac_coef      = a1_q;
		mac_opnd      = d1_q;
		case (state_q)
			ST_FB: begin
				mac_ctl.issue = 1'b1;
				if (cnt_q[1]) begin
					mac_coef = a2_q;
					mac_opnd = d2_q;
				end
			end
			ST_FF: begin
				mac_ctl.issue = 1'b1;
				case (cnt_q[2:1])
					2'd0: begin
						mac_coef = b0_q;
						mac_opnd = w0_q;
					end
					2'd1: begin
						mac_coef = b1_q;
						mac_opnd = d1_q;
					end
					default: begin
						mac_coef = b2_q;
						mac_opnd = d2_q;
					end
				endcase
			end
			default: ;
		endcase
	end

	bqd_mac #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.DELAY_BITS     (DELAY_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (mac_coef),
		.opnd   (mac_opnd),
		.acc    (acc)
	);

	// the accumulator already holds the rounding constant: a shift is the floor
	assign scaled  = acc >>> COEF_FRAC_BITS;
	assign w0_wide = WW'(x_q) - WW'(scaled);
	assign w0_fits = (&w0_wide[WW-1:DELAY_BITS-1]) || !(|w0_wide[WW-1:DELAY_BITS-1]);
	assign y_fits  = (&scaled[ACC_W-1:SAMPLE_BITS-1]) || !(|scaled[ACC_W-1:SAMPLE_BITS-1]);

	always_comb begin
		if (y_fits) begin
			y_sat = scaled[SAMPLE_BITS-1:0];
		end else if (scaled[ACC_W-1]) begin
			y_sat = signed'({1'b1, {(SAMPLE_BITS-1){1'b0}}});
		end else begin
			y_sat = signed'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_FB;
						cnt_q   <= '0;
					end
				end
				ST_FB: begin
					if (cnt_q == FB_LAST) begin
						state_q <= ST_FB_DRAIN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_FB_DRAIN: state_q <= ST_W0;
				ST_W0:       state_q <= ST_FF;
				ST_FF: begin
					if (cnt_q == FF_LAST) begin
						state_q <= ST_FF_DRAIN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_FF_DRAIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample capture and new delay value
	always_ff @(posedge clk) begin
		if (in_beat) begin
			x_q <= in_ch.sample_in;
		end
		if (state_q == ST_W0) begin
			guard_q <= !w0_fits;
			if (w0_fits) begin
				w0_q <= w0_wide[DELAY_BITS-1:0];
			end else begin
				w0_q <= DELAY_BITS'(x_q);
			end
		end
	end

	// advance the delay line once the result is committed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (state_q == ST_OUT && out_free) begin
			d2_q <= d1_q;
			d1_q <= w0_q;
		end
	end

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_sample_q <= y_sat;
			out_guard_q  <= guard_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_sample_q;
	assign out_ch.guard_hit  = out_guard_q;

	// a stalled result beat must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=>
		(out_ch.valid && $stable(out_ch.sample_out) && $stable(out_ch.guard_hit)))
		else $error("result beat changed while stalled");

	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q <= ST_OUT)
		else $error("sequencer in an unused state");

	a_delay_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_OUT && out_free) |=> ($stable(d1_q) && $stable(d2_q)))
		else $error("delay line moved without a committed result");

endmodule

`default_nettype wire

// ===== src/bqd_mac.sv =====
// ----------------------------------------------------------------------------
// bqd_mac: shared multiply-accumulate unit
// One coefficient times one half-width limb of a delay value per cycle,
// product registered, then added (shifted for the upper limb) into a wide
// accumulator that starts from the half-up rounding constant.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_mac #(
	parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF,
	parameter int DELAY_BITS     = bqd_pkg::DELAY_BITS_DEF
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire bqd_pkg::bqd_mac_ctl_t                       ctl,
	input  wire logic signed [bqd_pkg::COEF_WIDTH-1:0]       coef,
	input  wire logic signed [DELAY_BITS-1:0]                opnd,
	output logic signed [bqd_pkg::COEF_WIDTH+DELAY_BITS+2:0] acc
);
	import bqd_pkg::*;

	localparam int LO_BITS = (DELAY_BITS + 1) / 2;
	localparam int HI_BITS = DELAY_BITS - LO_BITS;
	localparam int LIMB_W  = LO_BITS + 1;
	localparam int PROD_W  = COEF_WIDTH + LIMB_W;
	localparam int ACC_W   = COEF_WIDTH + DELAY_BITS + 3;
	localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

	logic signed [LIMB_W-1:0] limb;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     hi_s1;
	logic                     valid_s1;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  acc_q;

	// low limb is unsigned, upper limb carries the sign
	always_comb begin
		if (ctl.hi) begin
			limb = signed'({{(LIMB_W-HI_BITS){opnd[DELAY_BITS-1]}}, opnd[DELAY_BITS-1:LO_BITS]});
		end else begin
			limb = signed'({1'b0, opnd[LO_BITS-1:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(coef * limb);
		hi_s1   <= ctl.hi;
	end

	always_comb begin
		if (hi_s1) begin
			addend = ACC_W'(prod_s1) <<< LO_BITS;
		end else begin
			addend = ACC_W'(prod_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= RND;
		end else if (valid_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	assign acc = acc_q;

	// a restart must never drop a product still in flight
	a_clear_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |-> !valid_s1)
		else $error("accumulator cleared with a product pending");

	a_prod_from_issue: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(ctl.issue))
		else $error("product valid without an issued multiply");

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 && !ctl.clear) |=> $stable(acc_q))
		else $error("accumulator moved with no product");

endmodule

`default_nettype wire
